[rtl/spt_pkg.sv]
package spt_pkg;

    localparam int DEPTH       = 64;
    localparam int CELL_IDX_W  = $clog2(DEPTH);
    localparam int COUNT_W     = $clog2(DEPTH + 1);
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = DEPTH / GROUP_SIZE;
    localparam int GROUP_IDX_W = $clog2(GROUP_SIZE);
    localparam int GSEL_W      = $clog2(NUM_GROUPS);

    localparam int KEY_W  = 16;
    localparam int ADDR_W = 32;
    localparam int POS_W  = 7;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_DUP   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } state_t;

    typedef struct packed {
        cmd_t              command;
        logic [KEY_W-1:0]  port_key;
        logic [ADDR_W-1:0] peer_address;
        logic [POS_W-1:0]  position;
        logic              want_existing;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic              found;
        logic [POS_W-1:0]  result_index;
        logic [KEY_W-1:0]  out_port;
        logic [ADDR_W-1:0] out_address;
        logic [POS_W-1:0]  entry_count;
    } rsp_t;

    // Per-cell controls driven by the sequencer in the top level.
    typedef struct packed {
        logic do_insert;
        logic do_remove;
        logic do_find;
        logic do_read;
        logic at_pos;
        logic above_pos;
        logic below_count;
    } cell_ctrl_t;

endpackage

[rtl/spt_req_if.sv]
interface spt_req_if
    import spt_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/spt_rsp_if.sv]
interface spt_rsp_if
    import spt_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/spt_cell.sv]
module spt_cell
    import spt_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [KEY_W-1:0]  cmp_key,
    input  logic [ADDR_W-1:0] new_addr,
    input  logic [KEY_W-1:0]  left_key,
    input  logic [ADDR_W-1:0] left_addr,
    input  logic [KEY_W-1:0]  right_key,
    input  logic [ADDR_W-1:0] right_addr,
    output logic [KEY_W-1:0]  key,
    output logic [ADDR_W-1:0] addr,
    output logic              hit
);

    logic [KEY_W-1:0]  key_reg;
    logic [ADDR_W-1:0] addr_reg;

    // Insert opens a gap by taking the lower neighbor; remove closes it by
    // taking the upper neighbor. Entries at or past the count hold don't-care data.
    always_ff @(posedge clk)
    begin
        if (ctrl.do_insert && ctrl.at_pos)
        begin
            key_reg  <= cmp_key;
            addr_reg <= new_addr;
        end
        else if (ctrl.do_insert && ctrl.above_pos)
        begin
            key_reg  <= left_key;
            addr_reg <= left_addr;
        end
        else if (ctrl.do_remove && (ctrl.at_pos || ctrl.above_pos))
        begin
            key_reg  <= right_key;
            addr_reg <= right_addr;
        end
    end

    always_comb
    begin
        hit = (ctrl.do_find && ctrl.below_count && (key_reg >= cmp_key))
            || (ctrl.do_read && ctrl.at_pos);
    end

    assign key  = key_reg;
    assign addr = addr_reg;

endmodule

[rtl/spt_group.sv]
module spt_group
    import spt_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                capture,
    input  logic [GROUP_SIZE-1:0]               hit,
    input  logic [GROUP_SIZE-1:0][KEY_W-1:0]    key,
    input  logic [GROUP_SIZE-1:0][ADDR_W-1:0]   addr,
    output logic                                any_hit,
    output logic [GROUP_IDX_W-1:0]              first_idx,
    output logic [KEY_W-1:0]                    first_key,
    output logic [ADDR_W-1:0]                   first_addr
);

    logic                   any_reg;
    logic [GROUP_IDX_W-1:0] idx_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [ADDR_W-1:0]      addr_reg;

    logic                   any_next;
    logic [GROUP_IDX_W-1:0] idx_next;

    // Lowest hit wins: scan from the top so the last match assigned is the lowest.
    always_comb
    begin
        any_next = 1'b0;
        idx_next = '0;
        for (int i = GROUP_SIZE - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                any_next = 1'b1;
                idx_next = GROUP_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else if (capture)
        begin
            any_reg <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            idx_reg  <= idx_next;
            key_reg  <= key[idx_next];
            addr_reg <= addr[idx_next];
        end
    end

    assign any_hit    = any_reg;
    assign first_idx  = idx_reg;
    assign first_key  = key_reg;
    assign first_addr = addr_reg;

endmodule

[rtl/sorted_peer_table.sv]
// A command is taken in S_IDLE; in S_EXEC the cells update and each group registers
// its first hit; S_FINISH waits for a free or draining output register, then loads
// the final selection across groups into it. A new command is taken after S_FINISH.
// A finished result waits in the output register while the next command is taken.
// Reset clears the entry count and the control state; table contents stay undefined.
module sorted_peer_table
    import spt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    spt_req_if.sink  req,
    spt_rsp_if.source rsp
);

    state_t state_reg, state_next;

    cmd_t              cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              want_reg;

    logic [COUNT_W-1:0] count_reg, count_next;
    status_t            st_reg, st_next;
    logic               ok_reg, ok_next;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_data_reg, rsp_data_next;

    logic ins_ok, rem_ok, read_ok, exec;

    cell_ctrl_t [DEPTH-1:0]             cell_ctrl;
    logic [DEPTH-1:0][KEY_W-1:0]        cell_key;
    logic [DEPTH-1:0][ADDR_W-1:0]       cell_addr;
    logic [DEPTH-1:0]                   cell_hit;

    logic [NUM_GROUPS-1:0]                   grp_any;
    logic [NUM_GROUPS-1:0][GROUP_IDX_W-1:0]  grp_idx;
    logic [NUM_GROUPS-1:0][KEY_W-1:0]        grp_key;
    logic [NUM_GROUPS-1:0][ADDR_W-1:0]       grp_addr;

    logic                  sel_any;
    logic [GSEL_W-1:0]     sel_g;
    logic [CELL_IDX_W-1:0] sel_pos;
    logic                  sel_eq;

    assign exec    = (state_reg == S_EXEC);
    assign ins_ok  = (cmd_reg == CMD_INSERT) && (count_reg != COUNT_W'(DEPTH))
                   && (pos_reg <= POS_W'(count_reg));
    assign rem_ok  = (cmd_reg == CMD_REMOVE) && (pos_reg < POS_W'(count_reg));
    assign read_ok = (cmd_reg == CMD_READ) && (pos_reg < POS_W'(count_reg));

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0]  left_key, right_key;
        logic [ADDR_W-1:0] left_addr, right_addr;

        always_comb
        begin
            cell_ctrl[i].do_insert   = exec && ins_ok;
            cell_ctrl[i].do_remove   = exec && rem_ok;
            cell_ctrl[i].do_find     = (cmd_reg == CMD_FIND);
            cell_ctrl[i].do_read     = read_ok;
            cell_ctrl[i].at_pos      = (pos_reg == POS_W'(i));
            cell_ctrl[i].above_pos   = (pos_reg < POS_W'(i));
            cell_ctrl[i].below_count = (COUNT_W'(i) < count_reg);
        end

        if (i == 0)
        begin : g_first
            assign left_key  = '0;
            assign left_addr = '0;
        end
        else
        begin : g_inner_left
            assign left_key  = cell_key[i-1];
            assign left_addr = cell_addr[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_key  = '0;
            assign right_addr = '0;
        end
        else
        begin : g_inner_right
            assign right_key  = cell_key[i+1];
            assign right_addr = cell_addr[i+1];
        end

        spt_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .cmp_key    (key_reg),
            .new_addr   (addr_reg),
            .left_key   (left_key),
            .left_addr  (left_addr),
            .right_key  (right_key),
            .right_addr (right_addr),
            .key        (cell_key[i]),
            .addr       (cell_addr[i]),
            .hit        (cell_hit[i])
        );
    end

    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_group
        spt_group u_group (
            .clk        (clk),
            .rst_n      (rst_n),
            .capture    (exec),
            .hit        (cell_hit[g*GROUP_SIZE +: GROUP_SIZE]),
            .key        (cell_key[g*GROUP_SIZE +: GROUP_SIZE]),
            .addr       (cell_addr[g*GROUP_SIZE +: GROUP_SIZE]),
            .any_hit    (grp_any[g]),
            .first_idx  (grp_idx[g]),
            .first_key  (grp_key[g]),
            .first_addr (grp_addr[g])
        );
    end

    always_comb
    begin
        sel_any = 1'b0;
        sel_g   = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                sel_any = 1'b1;
                sel_g   = GSEL_W'(g);
            end
        end
        sel_pos = {sel_g, grp_idx[sel_g]};
        sel_eq  = sel_any && (grp_key[sel_g] == key_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg  <= req.data.command;
            key_reg  <= req.data.port_key;
            addr_reg <= req.data.peer_address;
            pos_reg  <= req.data.position;
            want_reg <= req.data.want_existing;
        end
        st_reg       <= st_next;
        ok_reg       <= ok_next;
        rsp_data_reg <= rsp_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        st_next        = st_reg;
        ok_next        = ok_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        req.ready      = (state_reg == S_IDLE);

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                st_next = STAT_OK;
                ok_next = 1'b1;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (count_reg == COUNT_W'(DEPTH))
                        begin
                            st_next = STAT_FULL;
                            ok_next = 1'b0;
                        end
                        else if (!ins_ok)
                        begin
                            st_next = STAT_RANGE;
                            ok_next = 1'b0;
                        end
                        else
                        begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (!rem_ok)
                        begin
                            st_next = STAT_RANGE;
                            ok_next = 1'b0;
                        end
                        else
                        begin
                            count_next = count_reg - COUNT_W'(1);
                        end
                    end
                    CMD_READ:
                    begin
                        if (!read_ok)
                        begin
                            st_next = STAT_RANGE;
                            ok_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        st_next = STAT_OK;
                    end
                endcase
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // The result register must be free or draining this cycle.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_data_next              = '0;
                    rsp_data_next.status       = st_reg;
                    rsp_data_next.entry_count  = POS_W'(count_reg);
                    if (cmd_reg == CMD_FIND)
                    begin
                        rsp_data_next.found        = sel_eq;
                        rsp_data_next.result_index = sel_any ? POS_W'(sel_pos)
                                                             : POS_W'(count_reg);
                        rsp_data_next.status       = (sel_eq && !want_reg) ? STAT_DUP
                                                                           : STAT_OK;
                    end
                    else if ((cmd_reg == CMD_READ) && ok_reg)
                    begin
                        rsp_data_next.out_port    = grp_key[sel_g];
                        rsp_data_next.out_address = grp_addr[sel_g];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

[sim/sorted_peer_table_tb.sv]
`timescale 1ns / 100ps

module sorted_peer_table_tb;
    import spt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 10;

    logic clk;
    logic rst_n;

    spt_req_if req_ch ();
    spt_rsp_if rsp_ch ();

    sorted_peer_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Our own copy of the table, advanced as each command transaction is accepted.
    logic [KEY_W-1:0]  peer_keys [DEPTH];
    logic [ADDR_W-1:0] peer_addrs [DEPTH];
    int                peer_count;

    rsp_t reply_queue [$];

    int  fail_count;
    int  sent_count;
    int  checked_count;
    int  full_hits;
    int  dup_hits;
    int  range_hits;
    int  read_hits;
    int  cycle_count;
    int  recv_stall;
    bit  send_idle;
    bit  recv_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, reply_queue.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        else if (roll < 5)
            return KEY_W'($urandom_range(0, 31));  // narrow pool so equal keys show up
        else
            return KEY_W'($urandom());
    endfunction

    function automatic req_t make_req(cmd_t op, logic [KEY_W-1:0] key,
                                      logic [ADDR_W-1:0] addr, logic [POS_W-1:0] pos,
                                      logic want);
        req_t r;
        r.command       = op;
        r.port_key      = key;
        r.peer_address  = addr;
        r.position      = pos;
        r.want_existing = want;
        return r;
    endfunction

    // Applies one command to the table copy and returns the reply it should produce.
    function automatic rsp_t next_reply(req_t r);
        rsp_t res;
        int   n;
        int   idx;
        int   i;
        bit   stop;
        res  = '0;
        n    = peer_count;
        stop = 1'b0;
        case (r.command)
            CMD_FIND:
            begin
                idx = n;
                for (i = 0; i < n && !stop; i++)
                begin
                    if (peer_keys[i] >= r.port_key)
                    begin
                        idx  = i;
                        stop = 1'b1;
                    end
                end
                res.result_index = POS_W'(idx);
                if (idx < n && peer_keys[idx] == r.port_key)
                begin
                    res.found  = 1'b1;
                    res.status = r.want_existing ? STAT_OK : STAT_DUP;
                end
            end
            CMD_INSERT:
            begin
                if (n >= DEPTH)
                    res.status = STAT_FULL;
                else if (int'(r.position) > n)
                    res.status = STAT_RANGE;
                else
                begin
                    for (i = n; i > int'(r.position); i--)
                    begin
                        peer_keys[i]  = peer_keys[i-1];
                        peer_addrs[i] = peer_addrs[i-1];
                    end
                    peer_keys[r.position]  = r.port_key;
                    peer_addrs[r.position] = r.peer_address;
                    peer_count = n + 1;
                end
            end
            default:
            begin
                if (int'(r.position) >= n)
                    res.status = STAT_RANGE;
                else if (r.command == CMD_REMOVE)
                begin
                    for (i = r.position; i + 1 < n; i++)
                    begin
                        peer_keys[i]  = peer_keys[i+1];
                        peer_addrs[i] = peer_addrs[i+1];
                    end
                    peer_count = n - 1;
                end
                else
                begin
                    res.out_port    = peer_keys[r.position];
                    res.out_address = peer_addrs[r.position];
                end
            end
        endcase
        res.entry_count = POS_W'(peer_count);
        return res;
    endfunction

    task automatic send_cmd(input req_t cmd_in, output rsp_t predicted);
        int gap;
        gap = send_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= cmd_in;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = next_reply(cmd_in);
        reply_queue.push_back(predicted);
        sent_count++;
        case (predicted.status)
            STAT_FULL:  full_hits++;
            STAT_DUP:   dup_hits++;
            STAT_RANGE: range_hits++;
            default:    if (cmd_in.command == CMD_READ) read_hits++;
        endcase
    endtask

    task automatic send(input cmd_t op, input logic [KEY_W-1:0] key,
                        input logic [ADDR_W-1:0] addr, input logic [POS_W-1:0] pos,
                        input logic want);
        rsp_t ignored;
        send_cmd(make_req(op, key, addr, pos, want), ignored);
    endtask

    task automatic wait_replies_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (reply_queue.size() != 0);
    endtask

    // Well-formed use of the table: look up the slot, then insert there.
    task automatic sorted_insert(input logic [KEY_W-1:0] key, input logic [ADDR_W-1:0] addr);
        rsp_t found_at;
        send_cmd(make_req(CMD_FIND, key, '0, '0, 1'($urandom_range(0, 1))), found_at);
        if (found_at.status != STAT_DUP || $urandom_range(0, 1) == 1)
            send(CMD_INSERT, key, addr, found_at.result_index, 1'b0);
    endtask

    task automatic send_noise();
        send(cmd_t'($urandom_range(0, 3)), KEY_W'($urandom()), $urandom(),
             POS_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    endtask

    always @(posedge clk)
    begin
        if (recv_stall > 0)
        begin
            recv_stall--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (recv_idle && $urandom_range(0, 3) == 0)
                recv_stall = pick_gap();
        end
    end

    always @(posedge clk)
    begin : reply_check
        rsp_t exp_r;
        rsp_t got_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_r = rsp_ch.data;
            if (reply_queue.size() == 0)
            begin
                $error("reply transaction with no command outstanding");
                fail_count++;
            end
            else
            begin
                exp_r = reply_queue.pop_front();
                checked_count++;
                if (got_r.status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, got_r.status);
                    fail_count++;
                end
                if (got_r.found !== exp_r.found)
                begin
                    $error("found: expected %0d, got %0d", exp_r.found, got_r.found);
                    fail_count++;
                end
                if (got_r.result_index !== exp_r.result_index)
                begin
                    $error("result_index: expected %0d, got %0d",
                           exp_r.result_index, got_r.result_index);
                    fail_count++;
                end
                if (got_r.out_port !== exp_r.out_port)
                begin
                    $error("out_port: expected %h, got %h", exp_r.out_port, got_r.out_port);
                    fail_count++;
                end
                if (got_r.out_address !== exp_r.out_address)
                begin
                    $error("out_address: expected %h, got %h",
                           exp_r.out_address, got_r.out_address);
                    fail_count++;
                end
                if (got_r.entry_count !== exp_r.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_r.entry_count, got_r.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Edge values, every command, errors on an empty table, equal keys,
    // an out-of-order insert and removal at both ends.
    task automatic test_directed();
        send(CMD_FIND,   16'h1234, '0, 7'd0, 1'b0);
        send(CMD_REMOVE, '0, '0, 7'd0, 1'b0);
        send(CMD_READ,   '0, '0, 7'd0, 1'b0);
        send(CMD_INSERT, 16'h0042, 32'h1, 7'd1, 1'b0);
        send(CMD_INSERT, 16'h0000, 32'h0, 7'd0, 1'b0);
        send(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 7'd1, 1'b0);
        send(CMD_INSERT, 16'h8000, 32'hA5A5_A5A5, 7'd1, 1'b0);
        send(CMD_FIND,   16'h0000, '0, 7'd0, 1'b0);
        send(CMD_FIND,   16'h0000, '0, 7'd0, 1'b1);
        send(CMD_FIND,   16'hFFFF, '0, 7'd0, 1'b1);
        send(CMD_FIND,   16'h8001, '0, 7'd0, 1'b0);
        send(CMD_FIND,   16'h7FFF, '0, 7'd0, 1'b1);
        send(CMD_READ,   '0, '0, 7'd0, 1'b0);
        send(CMD_READ,   '0, '0, 7'd2, 1'b0);
        send(CMD_READ,   '0, '0, 7'd3, 1'b0);
        send(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 7'd127, 1'b1);
        send(CMD_REMOVE, '0, '0, 7'd127, 1'b0);
        send(CMD_READ,   '0, '0, 7'd127, 1'b0);
        // The table does not enforce order: a small key goes at the end.
        send(CMD_INSERT, 16'h0001, 32'h5A5A_5A5A, 7'd3, 1'b0);
        send(CMD_FIND,   16'h0002, '0, 7'd0, 1'b0);
        send(CMD_REMOVE, '0, '0, 7'd3, 1'b0);
        send(CMD_REMOVE, '0, '0, 7'd0, 1'b0);
        send(CMD_READ,   '0, '0, 7'd0, 1'b0);
        wait_replies_drained();
    endtask

    task automatic test_fill_and_drain();
        int pos;
        while (peer_count < DEPTH)
            sorted_insert(pick_key(), $urandom());
        send(CMD_INSERT, 16'h1111, 32'h2222_2222, 7'd0, 1'b0);
        send(CMD_INSERT, 16'h1111, 32'h2222_2222, 7'd127, 1'b0);
        send(CMD_FIND,   pick_key(), '0, 7'd0, 1'b1);
        send(CMD_FIND,   16'hFFFF, '0, 7'd0, 1'b0);
        send(CMD_READ,   '0, '0, 7'(DEPTH - 1), 1'b0);
        send(CMD_READ,   '0, '0, 7'(DEPTH), 1'b0);
        send(CMD_REMOVE, '0, '0, 7'(DEPTH), 1'b0);
        wait_replies_drained();
        while (peer_count > 0)
        begin
            pos = $urandom_range(0, peer_count - 1);
            if ($urandom_range(0, 3) == 0)
                send(CMD_READ, '0, '0, 7'(pos), 1'b0);
            send(CMD_REMOVE, KEY_W'($urandom()), $urandom(), 7'(pos), 1'b0);
        end
        wait_replies_drained();
    endtask

    // Swings the fill level between empty and full, with well-formed lookups
    // and inserts, valid reads and removes, and some unconstrained commands.
    task automatic test_random_traffic(input int n_items);
        int  stop_at;
        int  pick;
        int  ins_w;
        int  rem_w;
        int  round;
        bit  growing;
        stop_at = sent_count + n_items;
        growing = 1'b1;
        round   = 0;
        while (sent_count < stop_at)
        begin
            if (peer_count >= DEPTH)
                growing = 1'b0;
            else if (peer_count == 0)
                growing = 1'b1;
            if (round % 60 == 0)
            begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            if (round % 150 == 149)
                wait_replies_drained();
            round++;
            ins_w = growing ? 50 : 10;
            rem_w = growing ? 8 : 48;
            pick  = $urandom_range(0, 99);
            if (pick < ins_w)
                sorted_insert(pick_key(), $urandom());
            else if (pick < ins_w + rem_w && peer_count > 0)
                send(CMD_REMOVE, KEY_W'($urandom()), $urandom(),
                     7'($urandom_range(0, peer_count - 1)), 1'($urandom_range(0, 1)));
            else if (pick < ins_w + rem_w + 15 && peer_count > 0)
                send(CMD_READ, KEY_W'($urandom()), $urandom(),
                     7'($urandom_range(0, peer_count - 1)), 1'($urandom_range(0, 1)));
            else if (pick < ins_w + rem_w + 28)
                send(CMD_FIND, pick_key(), $urandom(), POS_W'($urandom()),
                     1'($urandom_range(0, 1)));
            else
                send_noise();
        end
        wait_replies_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        rsp_ch.ready  = 1'b0;
        peer_count    = 0;
        fail_count    = 0;
        sent_count    = 0;
        checked_count = 0;
        full_hits     = 0;
        dup_hits      = 0;
        range_hits    = 0;
        read_hits     = 0;
        cycle_count   = 0;
        recv_stall    = 0;
        send_idle     = 1'b0;
        recv_idle     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        test_directed();
        test_fill_and_drain();
        test_random_traffic(400);

        wait_replies_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d commands and %0d checked replies over %0d cycles.",
                 sent_count, checked_count, cycle_count);
        $display("Outcomes seen: %0d full-table, %0d duplicate, %0d bad-position, %0d reads.",
                 full_hits, dup_hits, range_hits, read_hits);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
